>>> rtl/ultrasonic_range_stop_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// ultrasonic range stop controller assertion macros
// shared property forms for the range stop controller checks
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_STOP_CONTROLLER_UNIT_DEFINES_SVH
`define ULTRASONIC_RANGE_STOP_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define USRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define USRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/usrs_pkg.sv
// ----------------------------------------------------------------------------
// usrs_pkg
// types, codes and the centimetre conversion for the range stop controller
// ----------------------------------------------------------------------------
`default_nettype none

package usrs_pkg;

  // event codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_RISE = 2'd1,
    CMD_FALL = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_STOP_DIST = 3'd0,
    REG_MAX_VALID = 3'd1,
    REG_RUN_DUTY  = 3'd2,
    REG_TRIG_INT  = 3'd3,
    REG_ECHO_TMO  = 3'd4
  } reg_idx_t;

  localparam int CMD_W     = 2;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;
  localparam int OUT_DAT_W = 24;

  // register reset values
  localparam logic [7:0] STOP_DIST_RST = 8'd10;
  localparam logic [7:0] MAX_VALID_RST = 8'd250;
  localparam logic [9:0] RUN_DUTY_RST  = 10'd700;
  localparam logic [7:0] TRIG_INT_RST  = 8'd30;
  localparam logic [7:0] ECHO_TMO_RST  = 8'd25;

  // distance before any valid reading
  localparam logic [8:0] NO_READING = 9'd256;

  // echo microseconds per centimetre, and the width past which no
  // quotient can fit in eight bits
  localparam int US_PER_CM   = 58;
  localparam int RANGE_LIMIT = US_PER_CM * 256;
  localparam int SMALL_W     = 14;
  // ceil(2^20 / 58); exact for widths below RANGE_LIMIT
  localparam int RECIP_SHIFT = 20;
  localparam logic [14:0] RECIP = 15'd18079;

  typedef struct packed {
    logic [7:0] stop_distance_cm;
    logic [7:0] max_range_cm;
    logic [9:0] run_duty;
    logic [7:0] trigger_interval_ms;
    logic [7:0] echo_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic       new_measurement;
    logic [8:0] distance_cm;
    logic [9:0] duty;
    logic       motor_run;
    logic       fire_trigger;
  } res_t;

  // width / 58 for widths below RANGE_LIMIT, by reciprocal multiply
  function automatic logic [7:0] cm_of_width(input logic [SMALL_W-1:0] w);
    logic [28:0] prod;
    prod = 29'(w) * 29'(RECIP);
    return prod[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

`default_nettype wire

>>> rtl/usrs_cfg.sv
// ----------------------------------------------------------------------------
// usrs_cfg
// configuration register file with write decode and reset values
// ----------------------------------------------------------------------------
`default_nettype none

module usrs_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_en,
  input  wire logic [usrs_pkg::CFG_IDX_W-1:0]    wr_idx,
  input  wire logic [usrs_pkg::CFG_DAT_W-1:0]    wr_data,
  output usrs_pkg::cfg_t                         cfg
);

  usrs_pkg::cfg_t cfg_r;
  usrs_pkg::cfg_t cfg_nxt;

  // index decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        usrs_pkg::REG_STOP_DIST: cfg_nxt.stop_distance_cm    = wr_data[7:0];
        usrs_pkg::REG_MAX_VALID: cfg_nxt.max_range_cm        = wr_data[7:0];
        usrs_pkg::REG_RUN_DUTY:  cfg_nxt.run_duty            = wr_data;
        usrs_pkg::REG_TRIG_INT:  cfg_nxt.trigger_interval_ms = wr_data[7:0];
        usrs_pkg::REG_ECHO_TMO:  cfg_nxt.echo_limit_ms       = wr_data[7:0];
        default: ;
      endcase
    end
  end

  // register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_distance_cm    <= usrs_pkg::STOP_DIST_RST;
      cfg_r.max_range_cm        <= usrs_pkg::MAX_VALID_RST;
      cfg_r.run_duty            <= usrs_pkg::RUN_DUTY_RST;
      cfg_r.trigger_interval_ms <= usrs_pkg::TRIG_INT_RST;
      cfg_r.echo_limit_ms       <= usrs_pkg::ECHO_TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/usrs_core.sv
// ----------------------------------------------------------------------------
// usrs_core
// ranging state and the single-pass event update: timers, echo width,
// distance and motor decision
// ----------------------------------------------------------------------------
`default_nettype none

module usrs_core #(
  parameter int TIMESTAMP_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [usrs_pkg::CMD_W-1:0]     cmd,
  input  wire logic [usrs_pkg::TIME_W-1:0]    time_us,
  input  wire usrs_pkg::cfg_t                 cfg,
  output usrs_pkg::res_t                      res
);

  localparam int TW = (TIMESTAMP_BITS < usrs_pkg::TIME_W) ? TIMESTAMP_BITS
                                                          : usrs_pkg::TIME_W;

  logic [31:0]               ms_r, ms_nxt;
  logic [31:0]               last_r, last_nxt;
  logic                      pend_r, pend_nxt;
  logic [7:0]                wait_r, wait_nxt;
  logic [TIMESTAMP_BITS-1:0] rise_r, rise_nxt;
  logic [8:0]                dist_r, dist_nxt;

  logic [TIMESTAMP_BITS-1:0] t_ext;
  logic [TIMESTAMP_BITS-1:0] echo_w;
  logic                      in_range;
  logic [7:0]                cm;
  logic [8:0]                wait_sum;
  logic [31:0]               ms_inc;
  logic                      interval_up;
  logic                      fire;
  logic                      fresh;
  logic                      blocked;

  // timestamp masked to the counter width, and echo width modulo that width
  assign t_ext    = TIMESTAMP_BITS'(time_us[TW-1:0]);
  assign echo_w   = t_ext - rise_r;
  assign in_range = echo_w < TIMESTAMP_BITS'(usrs_pkg::RANGE_LIMIT);
  assign cm       = usrs_pkg::cm_of_width(echo_w[usrs_pkg::SMALL_W-1:0]);

  // tick arithmetic
  assign wait_sum    = {1'b0, wait_r} + 9'd1;
  assign ms_inc      = ms_r + 32'd1;
  assign interval_up = (ms_inc - last_r) >= {24'd0, cfg.trigger_interval_ms};

  // event update
  always_comb begin
    ms_nxt   = ms_r;
    last_nxt = last_r;
    pend_nxt = pend_r;
    wait_nxt = wait_r;
    rise_nxt = rise_r;
    dist_nxt = dist_r;
    fire     = 1'b0;
    fresh    = 1'b0;
    case (cmd)
      usrs_pkg::CMD_TICK: begin
        ms_nxt = ms_inc;
        if (pend_r) begin
          if (wait_sum >= {1'b0, cfg.echo_limit_ms}) begin
            pend_nxt = 1'b0;
            wait_nxt = 8'd0;
          end else begin
            wait_nxt = wait_sum[7:0];
          end
        end else begin
          wait_nxt = 8'd0;
        end
        if (interval_up) begin
          last_nxt = ms_inc;
          if (!pend_nxt) begin
            pend_nxt = 1'b1;
            fire     = 1'b1;
          end
        end
      end
      usrs_pkg::CMD_RISE: begin
        rise_nxt = t_ext;
      end
      usrs_pkg::CMD_FALL: begin
        if (pend_r) begin
          pend_nxt = 1'b0;
          fresh    = 1'b1;
          if (in_range && (cm != 8'd0) && (cm <= cfg.max_range_cm)) begin
            dist_nxt = {1'b0, cm};
          end
        end
      end
      default: ;
    endcase
  end

  // motor decision on the updated distance
  assign blocked = (dist_nxt != 9'd0) && (dist_nxt <= {1'b0, cfg.stop_distance_cm});

  assign res.fire_trigger    = fire;
  assign res.motor_run       = !blocked;
  assign res.duty            = blocked ? 10'd0 : cfg.run_duty;
  assign res.distance_cm     = dist_nxt;
  assign res.new_measurement = fresh;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r   <= 32'd0;
      last_r <= 32'd0;
      pend_r <= 1'b0;
      wait_r <= 8'd0;
      rise_r <= '0;
      dist_r <= usrs_pkg::NO_READING;
    end else if (step) begin
      ms_r   <= ms_nxt;
      last_r <= last_nxt;
      pend_r <= pend_nxt;
      wait_r <= wait_nxt;
      rise_r <= rise_nxt;
      dist_r <= dist_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ultrasonic_range_stop_controller_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic range stop controller unit
// Events enter on the in_ stream: tuser holds the event kind (tick, echo
// rise, echo fall), tdata the microsecond timestamp of an edge. Every event
// gives exactly one result word on the out_ stream with the trigger request,
// motor run flag, duty, last distance and a new-measurement flag.
// Registers are written on the cfg_ channel (always ready); the user must
// write them only while idle; the block does not enforce it. A word in the
// input register is processed there and loaded into the result register,
// which drives out_tvalid. Throughput: one word per cycle while the receiver
// does not stall; the state update is one pass through the timer compares
// and the echo width subtract, divide-by-58 multiply and range compare.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; after that in_tready drops until
// out_tready returns.
// Reset: both stages empty, timers and echo state cleared, no distance
// reading (256), registers at their default values.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ultrasonic_range_stop_controller_unit_defines.svh"

module ultrasonic_range_stop_controller_unit #(
  parameter int TIMESTAMP_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [usrs_pkg::TIME_W-1:0]       in_tdata,   // [31:0] time_us
  input  wire logic [usrs_pkg::CMD_W-1:0]        in_tuser,   // [1:0] command
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] fire_trigger, [1] motor_run, [11:2] duty, [20:12] distance_cm,
  // [21] new_measurement, [23:22] zero
  output logic [usrs_pkg::OUT_DAT_W-1:0]         out_tdata,
  // configuration write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [usrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [usrs_pkg::CFG_DAT_W-1:0]    cfg_data
);

  logic                               s1_valid_r;
  logic [usrs_pkg::CMD_W-1:0]         s1_cmd_r;
  logic [usrs_pkg::TIME_W-1:0]        s1_time_r;
  logic                               out_valid_r;
  logic [usrs_pkg::OUT_DAT_W-1:0]     out_data_r;
  logic                               out_load;
  logic                               s1_adv;
  logic                               in_acc;
  usrs_pkg::cfg_t                     cfg;
  usrs_pkg::res_t                     res;

  // handshake
  assign out_load  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  usrs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // event processing
  usrs_core #(
    .TIMESTAMP_BITS (TIMESTAMP_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .cmd     (s1_cmd_r),
    .time_us (s1_time_r),
    .cfg     (cfg),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_tuser;
      s1_time_r <= in_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {2'b00, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `USRS_ASSERT_NOW(a_fire_excl, out_tvalid, !(out_tdata[0] && out_tdata[21]), "trigger and measurement in one word")
  `USRS_ASSERT_NOW(a_stop_duty, out_tvalid && !out_tdata[1], out_tdata[11:2] == 10'd0, "stopped motor with nonzero duty")
  `USRS_ASSERT_NOW(a_no_overrun, in_tready && out_tvalid && !out_tready, !s1_valid_r, "input taken over a full stage")
  `USRS_ASSERT_NEXT(a_result_out, s1_adv, out_tvalid, "processed word not presented")

endmodule

`default_nettype wire
